FILE: hdl/siph_pkg.sv
// Shared types, constants and the SipRound function for the SipHash-2-4 stream block.
// Used by siph_front, siph_fifo, siph_core and siphash_2_4_stream.
// No dependencies.
package siph_pkg;

    localparam int unsigned COMPRESS_ROUNDS = 2;
    localparam int unsigned FINAL_ROUNDS    = 4;
    localparam int unsigned MAX_ROUNDS      = (COMPRESS_ROUNDS > FINAL_ROUNDS) ?
                                              COMPRESS_ROUNDS : FINAL_ROUNDS;
    localparam int unsigned CNT_W           = $clog2(MAX_ROUNDS + 1);

    localparam logic [63:0] INIT_C0    = 64'h736f6d6570736575;
    localparam logic [63:0] INIT_C1    = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT_C2    = 64'h6c7967656e657261;
    localparam logic [63:0] INIT_C3    = 64'h7465646279746573;
    localparam logic [63:0] FINAL_FLIP = 64'h00000000000000ff;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [63:0] v3;
        logic [63:0] v2;
        logic [63:0] v1;
        logic [63:0] v0;
    } lanes_t;

    // One block for the compression engine; fin marks the block that closes a message.
    typedef struct packed {
        logic        fin;
        logic [63:0] blk;
    } blk_entry_t;

    // Key update seen by the front end and the engine.
    typedef struct packed {
        logic        load;
        logic [63:0] key_low;
        logic [63:0] key_high;
    } key_ctrl_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_COMPRESS,
        ENG_FINAL
    } eng_state_t;

    function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned s);
        rotl = (v << s) | (v >> (64 - s));
    endfunction

    function automatic lanes_t sip_round(input lanes_t l);
        lanes_t r;
        r = l;
        r.v0 = r.v0 + r.v1;
        r.v1 = rotl(r.v1, 13) ^ r.v0;
        r.v0 = rotl(r.v0, 32);
        r.v2 = r.v2 + r.v3;
        r.v3 = rotl(r.v3, 16) ^ r.v2;
        r.v0 = r.v0 + r.v3;
        r.v3 = rotl(r.v3, 21) ^ r.v0;
        r.v2 = r.v2 + r.v1;
        r.v1 = rotl(r.v1, 17) ^ r.v2;
        r.v2 = rotl(r.v2, 32);
        sip_round = r;
    endfunction

    function automatic lanes_t init_lanes(input logic [63:0] k0, input logic [63:0] k1);
        lanes_t r;
        r.v0 = k0 ^ INIT_C0;
        r.v1 = k1 ^ INIT_C1;
        r.v2 = k0 ^ INIT_C2;
        r.v3 = k1 ^ INIT_C3;
        init_lanes = r;
    endfunction

endpackage

FILE: hdl/siph_front.sv
// Front end: accepts message words, keeps the length byte and builds the blocks.
// Depends on siph_pkg; feeds siph_fifo.
module siph_front
    import siph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  key_ctrl_t   key,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] in_word,
    input  logic [3:0]  in_count,
    input  logic        in_last,
    output logic        push,
    output blk_entry_t  push_entry,
    input  logic        q_full
);

    logic [7:0] length_reg, length_next;
    logic       pend_reg, pend_next;
    logic       accept;
    logic [7:0] tail_len;
    logic [63:0] tail_blk;

    assign in_ready = !pend_reg && !q_full;
    assign accept   = in_valid && in_ready;
    assign tail_len = length_reg + {4'd0, in_count};

    always_comb
    begin
        tail_blk = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < in_count)
            begin
                tail_blk[8*i +: 8] = in_word[8*i +: 8];
            end
        end
        tail_blk[63:56] = tail_len;
    end

    always_comb
    begin
        push        = 1'b0;
        push_entry  = '0;
        length_next = length_reg;
        pend_next   = pend_reg;
        if (pend_reg)
        begin
            // Length-only block after a final word that was full.
            if (!q_full)
            begin
                push           = 1'b1;
                push_entry.fin = 1'b1;
                push_entry.blk = {length_reg, 56'd0};
                length_next    = '0;
                pend_next      = 1'b0;
            end
        end
        else if (accept)
        begin
            push = 1'b1;
            if (!in_last || in_count[3])
            begin
                push_entry.fin = 1'b0;
                push_entry.blk = in_word;
                length_next    = length_reg + 8'd8;
                pend_next      = in_last;
            end
            else
            begin
                push_entry.fin = 1'b1;
                push_entry.blk = tail_blk;
                length_next    = '0;
            end
        end
        if (key.load)
        begin
            length_next = '0;
            pend_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            length_reg <= length_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

FILE: hdl/siph_fifo.sv
// Short block queue between the front end and the compression engine.
// Depends on siph_pkg.
module siph_fifo
    import siph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  blk_entry_t push_entry,
    input  logic       pop,
    output blk_entry_t head,
    output logic       empty,
    output logic       full
);

    blk_entry_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: hdl/siph_core.sv
// Compression engine: one SipRound per cycle on the four lanes unless held by an unread hash;
// finalization and result register. Depends on siph_pkg; takes blocks from siph_fifo.
module siph_core
    import siph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  key_ctrl_t   key,
    input  blk_entry_t  q_head,
    input  logic        q_empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_hash
);

    eng_state_t       state_reg, state_next;
    lanes_t           lanes_reg, lanes_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]      blk_reg, blk_next;
    logic             fin_reg, fin_next;
    logic [63:0]      hash_reg, hash_next;
    logic             out_valid_reg, out_valid_next;

    logic             start;
    logic [63:0]      blk_cur;
    logic             fin_cur;
    logic [CNT_W-1:0] comp_idx;
    logic             comp_last;
    logic             final_last;
    logic             hold;
    logic             finish;
    lanes_t           round_in, round_out, comp_end;

    always_comb
    begin
        start      = (state_reg == ENG_IDLE) && !q_empty;
        blk_cur    = start ? q_head.blk : blk_reg;
        fin_cur    = start ? q_head.fin : fin_reg;
        comp_idx   = (state_reg == ENG_COMPRESS) ? cnt_reg : '0;
        comp_last  = (start || state_reg == ENG_COMPRESS) &&
                     (comp_idx == CNT_W'(COMPRESS_ROUNDS - 1));
        final_last = (state_reg == ENG_FINAL) && (cnt_reg == CNT_W'(FINAL_ROUNDS - 1));
        // The result register must be free before a finished hash can land in it.
        hold       = final_last && out_valid_reg && !out_ready;
        finish     = final_last && !hold;
        round_in   = lanes_reg;
        if (start)
        begin
            round_in.v3 = lanes_reg.v3 ^ q_head.blk;
        end
        round_out   = sip_round(round_in);
        comp_end    = round_out;
        comp_end.v0 = round_out.v0 ^ blk_cur;
        if (fin_cur)
        begin
            comp_end.v2 = round_out.v2 ^ FINAL_FLIP;
        end
    end

    assign pop = start;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE:
            begin
                if (start)
                begin
                    if (comp_last)
                    begin
                        state_next = fin_cur ? ENG_FINAL : ENG_IDLE;
                    end
                    else
                    begin
                        state_next = ENG_COMPRESS;
                    end
                end
            end
            ENG_COMPRESS:
            begin
                if (comp_last)
                begin
                    state_next = fin_cur ? ENG_FINAL : ENG_IDLE;
                end
            end
            ENG_FINAL:
            begin
                if (finish)
                begin
                    state_next = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_comb
    begin
        lanes_next     = lanes_reg;
        cnt_next       = cnt_reg;
        blk_next       = blk_reg;
        fin_next       = fin_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ENG_IDLE:
            begin
                if (start)
                begin
                    blk_next   = q_head.blk;
                    fin_next   = q_head.fin;
                    lanes_next = comp_last ? comp_end : round_out;
                    cnt_next   = comp_last ? '0 : CNT_W'(1);
                end
            end
            ENG_COMPRESS:
            begin
                lanes_next = comp_last ? comp_end : round_out;
                cnt_next   = comp_last ? '0 : cnt_reg + CNT_W'(1);
            end
            ENG_FINAL:
            begin
                if (finish)
                begin
                    hash_next      = round_out.v0 ^ round_out.v1 ^ round_out.v2 ^ round_out.v3;
                    out_valid_next = 1'b1;
                    lanes_next     = init_lanes(key.key_low, key.key_high);
                    cnt_next       = '0;
                end
                else if (!hold)
                begin
                    lanes_next = round_out;
                    cnt_next   = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
        if (key.load)
        begin
            lanes_next = init_lanes(key.key_low, key.key_high);
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        fin_reg  <= fin_next;
        hash_reg <= hash_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            lanes_reg     <= init_lanes('0, '0);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lanes_reg     <= lanes_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hash  = hash_reg;

`ifndef SYNTH
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ENG_IDLE)
        else $error("block taken from queue while engine busy");

    a_comp_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ENG_COMPRESS |-> cnt_reg < CNT_W'(COMPRESS_ROUNDS))
        else $error("compression round count out of range");

    a_final_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ENG_FINAL |-> cnt_reg < CNT_W'(FINAL_ROUNDS))
        else $error("finalization round count out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> !out_valid_reg || out_ready)
        else $error("unread hash overwritten");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg && state_reg == ENG_IDLE)
        else $error("finished hash not presented");
`endif

endmodule

FILE: hdl/siphash_2_4_stream.sv
// SipHash-2-4 stream block: top level with the key registers.
// Depends on siph_pkg, siph_front, siph_fifo and siph_core.
//
// Usage:
//   s_axis carries message words: tdata holds the 64-bit word (first byte in the low
//   bits) and the byte count; tlast marks the final word of a message. Only the final
//   word may hold fewer than eight bytes; other words are always taken as full.
//   m_axis carries one 64-bit hash for each message, after its final word.
//   The key is written through cfg_we / cfg_index / cfg_wdata (index 0: low key half,
//   index 1: high key half) while the block is idle; a write restarts the message.
// Timing:
//   The engine runs one SipRound per cycle unless an unread hash holds it; a word
//   costs two SipRounds of the lane registers, and the four-entry queue lets the input
//   take words back to back until it fills. The final word costs two compression rounds
//   plus four finalization rounds, plus two more when it holds eight bytes (an extra
//   length block). The hash appears on m_axis the cycle after the last finalization round.
// Reset:
//   rst_n clears the keys to zero, loads the lanes from them and empties the queue.
//   If m_axis stalls, the hash waits in its register; the engine holds at the last
//   finalization round of the next message and the input backs up through the queue.
module siphash_2_4_stream
    import siph_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [71:0]          s_axis_tdata,  // message_word[63:0], byte_count[67:64], zero
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,  // hash_value[63:0]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_wdata
);

    logic [63:0] key_low_reg, key_low_next;
    logic [63:0] key_high_reg, key_high_next;
    key_ctrl_t   key;
    logic        push;
    blk_entry_t  push_entry;
    logic        pop;
    blk_entry_t  q_head;
    logic        q_empty;
    logic        q_full;

    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        key.load      = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_LOW:
                begin
                    key_low_next = cfg_wdata;
                    key.load     = 1'b1;
                end
                REG_KEY_HIGH:
                begin
                    key_high_next = cfg_wdata;
                    key.load      = 1'b1;
                end
                default:
                begin
                    key.load = 1'b0;
                end
            endcase
        end
        // The engine reloads its lanes from the key as it stands after this edge.
        key.key_low  = key_low_next;
        key.key_high = key_high_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else
        begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
        end
    end

    siph_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_word    (s_axis_tdata[63:0]),
        .in_count   (s_axis_tdata[67:64]),
        .in_last    (s_axis_tlast),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    siph_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    siph_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hash  (m_axis_tdata)
    );

endmodule
